>>> sv/kpd_pkg.sv
// ----------------------------------------------------------------------------
// kpd_pkg: shared types and constants for the keypad debounce block
// Field widths, the register map, reset values of the time settings and the
// structs that travel between the stages.
// ----------------------------------------------------------------------------
package kpd_pkg;

	localparam int unsigned MASK_W = 16;   // pressed_mask width
	localparam int unsigned TIME_W = 32;   // timestamp width
	localparam int unsigned CODE_W = 4;    // key code width
	localparam int unsigned SET_W  = 16;   // time setting width
	localparam int unsigned IDX_W  = 2;    // register index width

	localparam logic [SET_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [SET_W-1:0] DELAY_RST    = 16'd500;
	localparam logic [SET_W-1:0] PERIOD_RST   = 16'd100;

	typedef enum logic [IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_DELAY    = 2'd1,
		REG_PERIOD   = 2'd2
	} reg_idx_t;

	// resolved key; none set means no key or several keys
	typedef struct packed {
		logic              none;
		logic [CODE_W-1:0] code;
	} key_t;

	localparam key_t NO_KEY = '{none: 1'b1, code: '0};

	typedef struct packed {
		key_t              key;
		logic [TIME_W-1:0] now;
	} item_t;

	typedef struct packed {
		logic [SET_W-1:0] debounce_time;
		logic [SET_W-1:0] repeat_delay;
		logic [SET_W-1:0] repeat_period;
	} cfg_t;

	typedef struct packed {
		logic              key_valid;
		logic [CODE_W-1:0] key_code;
	} res_t;

endpackage

>>> sv/kpd_sample_if.sv
// ----------------------------------------------------------------------------
// kpd_sample_if: sample channel
// One word is a pressed-key mask and a millisecond timestamp.
// ----------------------------------------------------------------------------
interface kpd_sample_if;
	import kpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] pressed_mask;
	logic [TIME_W-1:0] now_ms;

	modport source (output valid, output pressed_mask, output now_ms, input ready);
	modport sink   (input valid, input pressed_mask, input now_ms, output ready);
endinterface

>>> sv/kpd_key_if.sv
// ----------------------------------------------------------------------------
// kpd_key_if: key report channel
// One word per sample: a report flag and the key code.
// ----------------------------------------------------------------------------
interface kpd_key_if;
	import kpd_pkg::*;

	logic              valid;
	logic              ready;
	logic              key_valid;
	logic [CODE_W-1:0] key_code;

	modport source (output valid, output key_valid, output key_code, input ready);
	modport sink   (input valid, input key_valid, input key_code, output ready);
endinterface

>>> sv/keypad_debounce_autorepeat.sv
// ----------------------------------------------------------------------------
// keypad_debounce_autorepeat: keypad debounce with auto-repeat
// Resolves keypad samples to single keys, debounces them and reports presses
// and timed repeats.
// ----------------------------------------------------------------------------
// Usage
//   sample: one word per scan, pressed_mask (bit row*NUM_COLS+col) and now_ms.
//   result: exactly one word per sample: key_valid and key_code (0 when no
//     report). Reports come for a newly stable key, once after repeat_delay
//     ms of holding, then every repeat_period ms.
//   cfg_*: write debounce_time (0), repeat_delay (1), repeat_period (2)
//     while no sample is in flight; other indexes are ignored.
// Pipeline: an accepted sample goes into the input register, then into the
//   result register, from which the result is taken.
// Throughput: one sample per cycle while result.ready is high; the debounce
//   state updates as the result register loads, so back-to-back samples see it.
// Stall: the result register holds while result.ready is low; the input
//   register still takes one more sample, then sample.ready drops.
// Reset: time settings go to 20/500/100 ms, no candidate, no stable key,
//   repeat off, both registers empty.
// ----------------------------------------------------------------------------
module keypad_debounce_autorepeat #(
	parameter int unsigned NUM_ROWS = 4,
	parameter int unsigned NUM_COLS = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	kpd_sample_if.sink                sample,
	kpd_key_if.source                 result,
	input  logic                      cfg_we,
	input  logic [kpd_pkg::IDX_W-1:0] cfg_index,
	input  logic [kpd_pkg::SET_W-1:0] cfg_wdata
);
	import kpd_pkg::*;

	// only keys inside the matrix count, at most the mask width
	localparam int unsigned KEY_CELLS = NUM_ROWS * NUM_COLS;
	localparam int unsigned KEY_COUNT = (KEY_CELLS > MASK_W) ? MASK_W : KEY_CELLS;

	cfg_t  cfg_q;
	key_t  key_res;
	item_t item_s1;
	logic  valid_s1;
	logic  trk_ready;
	logic  res_valid;
	res_t  res;
	logic  accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEBOUNCE_RST;
			cfg_q.repeat_delay  <= DELAY_RST;
			cfg_q.repeat_period <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_time <= cfg_wdata;
				REG_DELAY:    cfg_q.repeat_delay  <= cfg_wdata;
				REG_PERIOD:   cfg_q.repeat_period <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// key resolve ahead of the input register
	kpd_resolve #(
		.KEY_COUNT (KEY_COUNT)
	) u_resolve (
		.mask (sample.pressed_mask),
		.key  (key_res)
	);

	assign sample.ready = !valid_s1 || trk_ready;
	assign accept       = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (trk_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.key <= key_res;
			item_s1.now <= sample.now_ms;
		end
	end

	kpd_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (valid_s1),
		.item       (item_s1),
		.item_ready (trk_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_ready  (result.ready)
	);

	assign result.valid     = res_valid;
	assign result.key_valid = res.key_valid;
	assign result.key_code  = res.key_code;
endmodule

>>> sv/kpd_resolve.sv
// ----------------------------------------------------------------------------
// kpd_resolve: mask to single key
// Gives the key index when exactly one considered bit is set, else no key.
// ----------------------------------------------------------------------------
module kpd_resolve #(
	parameter int unsigned KEY_COUNT = 16
) (
	input  logic [kpd_pkg::MASK_W-1:0] mask,
	output kpd_pkg::key_t              key
);
	import kpd_pkg::*;

	logic [MASK_W-1:0] used;
	logic [MASK_W-1:0] rest;
	logic [CODE_W-1:0] code;
	logic              one_hot;

	always_comb begin
		used = '0;
		code = '0;
		for (int i = 0; i < MASK_W; i++) begin
			if (i < KEY_COUNT) begin
				used[i] = mask[i];
			end
		end
		// with one bit set the OR of set indices is that index
		for (int i = 0; i < MASK_W; i++) begin
			if (used[i]) begin
				code = code | CODE_W'(i);
			end
		end
	end

	assign rest    = used & (used - MASK_W'(1));
	assign one_hot = (used != '0) && (rest == '0);

	always_comb begin
		if (one_hot) begin
			key = '{none: 1'b0, code: code};
		end else begin
			key = NO_KEY;
		end
	end
endmodule

>>> sv/kpd_tracker.sv
// ----------------------------------------------------------------------------
// kpd_tracker: debounce and auto-repeat state with result register
// Updates candidate, stable key and repeat timing per word, loads the result.
// ----------------------------------------------------------------------------
module kpd_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  kpd_pkg::cfg_t  cfg,
	input  logic           item_valid,
	input  kpd_pkg::item_t item,
	output logic           item_ready,
	output logic           res_valid,
	output kpd_pkg::res_t  res,
	input  logic           res_ready
);
	import kpd_pkg::*;

	key_t              cand_q;
	logic [TIME_W-1:0] since_q;
	key_t              stable_q;
	logic [TIME_W-1:0] last_q;
	logic              repeat_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              take;
	logic              same;
	logic [TIME_W-1:0] held;
	logic [TIME_W-1:0] gap;
	logic              deb_ok;
	logic              delay_ok;
	logic              period_ok;

	key_t              cand_d;
	logic [TIME_W-1:0] since_d;
	key_t              stable_d;
	logic [TIME_W-1:0] last_d;
	logic              repeat_d;
	logic              report;

	assign item_ready = !res_valid_q || res_ready;
	assign take       = item_valid && item_ready;

	assign same      = (item.key == cand_q);
	assign held      = item.now - since_q;
	assign gap       = item.now - last_q;
	assign deb_ok    = held >= TIME_W'(cfg.debounce_time);
	assign delay_ok  = held >= TIME_W'(cfg.repeat_delay);
	assign period_ok = gap >= TIME_W'(cfg.repeat_period);

	always_comb begin
		cand_d   = cand_q;
		since_d  = since_q;
		stable_d = stable_q;
		last_d   = last_q;
		repeat_d = repeat_q;
		report   = 1'b0;
		if (!same) begin
			cand_d   = item.key;
			since_d  = item.now;
			repeat_d = 1'b0;
		end else if (deb_ok) begin
			if (item.key.none) begin
				if (!stable_q.none) begin
					stable_d = NO_KEY;
					repeat_d = 1'b0;
				end
			end else if (item.key != stable_q) begin
				stable_d = item.key;
				last_d   = item.now;
				repeat_d = 1'b0;
				report   = 1'b1;
			end else if (!repeat_q) begin
				if (delay_ok) begin
					repeat_d = 1'b1;
					last_d   = item.now;
					report   = 1'b1;
				end
			end else if (period_ok) begin
				last_d = item.now;
				report = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q      <= NO_KEY;
			since_q     <= '0;
			stable_q    <= NO_KEY;
			last_q      <= '0;
			repeat_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				cand_q      <= cand_d;
				since_q     <= since_d;
				stable_q    <= stable_d;
				last_q      <= last_d;
				repeat_q    <= repeat_d;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.key_valid <= report;
			res_q.key_code  <= report ? item.key.code : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a waiting report always names the current stable key
	a_report_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.key_valid) |-> (!stable_q.none && stable_q.code == res_q.key_code))
		else $error("reported key differs from stable key");

	a_repeat_needs_key: assert property (@(posedge clk) disable iff (!arst_n)
		repeat_q |-> !stable_q.none)
		else $error("repeating without a stable key");

	a_idle_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.key_valid) |-> (res_q.key_code == '0))
		else $error("nonzero code without a report");

	a_repeat_start_reports: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(repeat_q) |-> (res_valid_q && res_q.key_valid))
		else $error("repeat started without a report");
endmodule
